// File: rtl/core/tis_pkg.sv
// ----------------------------------------------------------------------------
// Thread interactivity score - shared definitions
// Field widths, scoring constants and the transaction layouts used by the
// serial accumulator, the decay units, the score divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tis_pkg;

  // Table geometry
  localparam int THREAD_SLOTS = 64;
  localparam int SLOT_W       = 6;

  // Time fields and history limit
  localparam int TIME_W      = 32;
  localparam int LIMIT_W     = 30;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd5000000;

  // Stored averages stay below twice the limit, hence one bit over the limit
  localparam int AVG_W   = LIMIT_W + 1;
  localparam int SUM_W   = TIME_W + 1;   // average plus elapsed time
  localparam int TOTAL_W = SUM_W + 1;    // run sum plus sleep sum

  // Decay by 4/5: multiply by 4 is a shift, divide by 5 is a serial divider
  localparam int DECAY_DIV   = 5;
  localparam int DECAY_SHIFT = 2;
  localparam int DECAY_REM_W = $clog2(DECAY_DIV);
  localparam int DECAY_STEPS = AVG_W + DECAY_SHIFT;

  // Scoring
  localparam int MAX_SCORE   = 100;
  localparam int HALF_SCORE  = MAX_SCORE / 2;
  localparam int SCORE_W     = 7;
  localparam int QUO_W       = $clog2(HALF_SCORE + 1);
  localparam int PROD_W      = AVG_W + QUO_W;
  localparam int SCORE_SUM_W = QUO_W + 1;

  // Stream layouts, padded to whole bytes
  localparam int IN_FIELDS_W  = SLOT_W + 2 * TIME_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SCORE_W + 2 * AVG_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  // Accumulator result handed to the sequencer
  typedef struct packed {
    logic [SUM_W-1:0] run_sum;
    logic [SUM_W-1:0] sleep_sum;
    logic             over_limit;
    logic             over_twice;
  } acc_result_t;

endpackage

`default_nettype wire

// File: rtl/core/tis_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tis_serial_acc.sv
// ----------------------------------------------------------------------------
// Bit-serial accumulator and limit comparator
// Adds elapsed times to both averages LSB first, forms their total and
// compares it against the limit and twice the limit, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_serial_acc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tis_pkg::AVG_W-1:0]    run_base,
  input  logic [tis_pkg::AVG_W-1:0]    sleep_base,
  input  logic [tis_pkg::TIME_W-1:0]   ran_us,
  input  logic [tis_pkg::TIME_W-1:0]   slept_us,
  input  logic [tis_pkg::LIMIT_W-1:0]  limit,
  output logic                         done,
  output tis_pkg::acc_result_t         result
);

  import tis_pkg::*;

  localparam int CNT_W = $clog2(TOTAL_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;

  logic [AVG_W-1:0]   run_a_r;
  logic [AVG_W-1:0]   sleep_a_r;
  logic [TIME_W-1:0]  run_b_r;
  logic [TIME_W-1:0]  sleep_b_r;
  logic [LIMIT_W-1:0] lim_r;
  logic               lim_prev_r;
  logic               c_run_r;
  logic               c_sleep_r;
  logic               c_tot_r;
  logic               gt1_r;
  logic               gt2_r;
  logic [SUM_W-1:0]   run_sum_r;
  logic [SUM_W-1:0]   sleep_sum_r;

  logic s_run, s_sleep, s_tot;
  logic c_run_nxt, c_sleep_nxt, c_tot_nxt;
  logic gt1_nxt, gt2_nxt;

  always_comb begin
    s_run       = run_a_r[0] ^ run_b_r[0] ^ c_run_r;
    c_run_nxt   = (run_a_r[0] & run_b_r[0]) | (c_run_r & (run_a_r[0] ^ run_b_r[0]));
    s_sleep     = sleep_a_r[0] ^ sleep_b_r[0] ^ c_sleep_r;
    c_sleep_nxt = (sleep_a_r[0] & sleep_b_r[0]) |
                  (c_sleep_r & (sleep_a_r[0] ^ sleep_b_r[0]));
    s_tot       = s_run ^ s_sleep ^ c_tot_r;
    c_tot_nxt   = (s_run & s_sleep) | (c_tot_r & (s_run ^ s_sleep));
    // LSB-first magnitude compare: a higher differing bit overrides
    gt1_nxt     = (s_tot & ~lim_r[0]) | (~(s_tot ^ lim_r[0]) & gt1_r);
    gt2_nxt     = (s_tot & ~lim_prev_r) | (~(s_tot ^ lim_prev_r) & gt2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TOTAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      run_a_r    <= run_base;
      sleep_a_r  <= sleep_base;
      run_b_r    <= ran_us;
      sleep_b_r  <= slept_us;
      lim_r      <= limit;
      lim_prev_r <= 1'b0;
      c_run_r    <= 1'b0;
      c_sleep_r  <= 1'b0;
      c_tot_r    <= 1'b0;
      gt1_r      <= 1'b0;
      gt2_r      <= 1'b0;
    end else if (busy_r) begin
      run_a_r    <= {1'b0, run_a_r[AVG_W-1:1]};
      sleep_a_r  <= {1'b0, sleep_a_r[AVG_W-1:1]};
      run_b_r    <= {1'b0, run_b_r[TIME_W-1:1]};
      sleep_b_r  <= {1'b0, sleep_b_r[TIME_W-1:1]};
      lim_r      <= {1'b0, lim_r[LIMIT_W-1:1]};
      lim_prev_r <= lim_r[0];
      c_run_r    <= c_run_nxt;
      c_sleep_r  <= c_sleep_nxt;
      c_tot_r    <= c_tot_nxt;
      gt1_r      <= gt1_nxt;
      gt2_r      <= gt2_nxt;
      // the sums are one bit narrower than the total: hold on the last bit
      if (cnt_r != CNT_W'(SUM_W)) begin
        run_sum_r   <= {s_run, run_sum_r[SUM_W-1:1]};
        sleep_sum_r <= {s_sleep, sleep_sum_r[SUM_W-1:1]};
      end
    end
  end

  assign done              = done_r;
  assign result.run_sum    = run_sum_r;
  assign result.sleep_sum  = sleep_sum_r;
  assign result.over_limit = gt1_r;
  assign result.over_twice = gt2_r;

endmodule

`default_nettype wire

// File: rtl/core/tis_decay.sv
// ----------------------------------------------------------------------------
// Bit-serial 4/5 decay
// Divides four times the value by five MSB first, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_decay (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tis_pkg::AVG_W-1:0] value,
  output logic                      done,
  output logic [tis_pkg::AVG_W-1:0] result
);

  import tis_pkg::*;

  localparam int CNT_W   = $clog2(DECAY_STEPS);
  localparam int TRIAL_W = DECAY_REM_W + 1;

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [AVG_W-1:0]       div_r;
  logic [DECAY_REM_W-1:0] rem_r;
  logic [AVG_W-1:0]       quo_r;

  logic [TRIAL_W-1:0]     trial;
  logic                   fits;
  logic [DECAY_REM_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, div_r[AVG_W-1]};
    fits    = (trial >= TRIAL_W'(DECAY_DIV));
    rem_nxt = fits ? DECAY_REM_W'(trial - TRIAL_W'(DECAY_DIV)) : DECAY_REM_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DECAY_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // the trailing zero bits of the dividend are the multiply by four
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= value;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      div_r <= {div_r[AVG_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[AVG_W-2:0], fits};
    end
  end

  assign done   = done_r;
  assign result = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/tis_score_div.sv
// ----------------------------------------------------------------------------
// Interactivity score divider
// Shift-subtract divider, one quotient bit a cycle, then offset and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_score_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tis_pkg::AVG_W-1:0]   run_avg,
  input  logic [tis_pkg::AVG_W-1:0]   sleep_avg,
  output logic                        done,
  output logic [tis_pkg::SCORE_W-1:0] score
);

  import tis_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  rem_r;
  logic [PROD_W-1:0]  den_sh_r;
  logic [QUO_W-1:0]   quo_r;
  logic               add_r;
  logic               zero_r;

  logic               sleep_gt;
  logic [AVG_W-1:0]   num;
  logic [AVG_W-1:0]   den;
  logic [PROD_W-1:0]  prod;
  logic               fits;
  logic [SCORE_SUM_W-1:0] sum;
  logic [SCORE_SUM_W-1:0] clamped;

  always_comb begin
    sleep_gt = (sleep_avg > run_avg);
    num      = sleep_gt ? run_avg : sleep_avg;
    den      = sleep_gt ? sleep_avg : run_avg;
    prod     = PROD_W'(num) * PROD_W'(HALF_SCORE);
    fits     = (rem_r >= den_sh_r);
    sum      = SCORE_SUM_W'(quo_r) + (add_r ? SCORE_SUM_W'(HALF_SCORE) : '0);
    clamped  = (sum > SCORE_SUM_W'(MAX_SCORE)) ? SCORE_SUM_W'(MAX_SCORE) : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient is at most half the score, so QUO_W steps cover it
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= prod;
      den_sh_r <= PROD_W'(den) << (QUO_W - 1);
      quo_r    <= '0;
      add_r    <= ~sleep_gt;
      zero_r   <= ~sleep_gt && (run_avg == '0);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_sh_r;
      end
      den_sh_r <= den_sh_r >> 1;
      quo_r    <= QUO_W'({quo_r, fits});
    end
  end

  assign done  = done_r;
  // both averages zero: no division, report half the maximum
  assign score = zero_r ? SCORE_W'(HALF_SCORE) : SCORE_W'(clamped);

endmodule

`default_nettype wire

// File: rtl/core/thread_interactivity_score_unit.sv
// ----------------------------------------------------------------------------
// Thread interactivity score unit
// Keeps per-slot run and sleep averages, folds in elapsed times, decays the
// history past the limit and reports an interactivity score per transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+-----------------------------------
//  in_     | slave     | tvalid/tready      | slot, ran_us, slept_us
//  out_    | master    | tvalid/tready      | score, run_average, sleep_average
//  cfg_    | write     | wr_en, no wait     | history_limit
//
//  A transaction passes through serial add and limit compare, serial 4/5
//  decay, score division, and table access and hand-offs before out_tvalid.
//  One transaction at a time; in_tready is high only when idle, so a new
//  transaction is accepted only after the last one has been retired.
//  A result stalled in the output register holds back only the next retirement.
//  Reset clears the valid bit of every slot at once; no clearing pass.
//
`default_nettype none

module thread_interactivity_score_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // slave side
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [5:0] slot, [37:6] ran_us, [69:38] slept_us, [71:70] zero
  input  logic [tis_pkg::IN_DATA_W-1:0]     in_tdata,
  // master side
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [6:0] score, [37:7] run_average, [68:38] sleep_average, [71:69] zero
  output logic [tis_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [tis_pkg::LIMIT_W-1:0]       cfg_wr_data
);

  import tis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DECAY,
    ST_SCORE,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [LIMIT_W-1:0]      limit_r;
  logic [THREAD_SLOTS-1:0] valid_r;
  logic                    valid_rd_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [TIME_W-1:0]       ran_r;
  logic [TIME_W-1:0]       slept_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic              in_accept;
  logic [SLOT_W-1:0] in_slot;
  logic              out_load;

  logic [AVG_W-1:0]  run_rd;
  logic [AVG_W-1:0]  sleep_rd;
  logic [AVG_W-1:0]  run_base;
  logic [AVG_W-1:0]  sleep_base;

  logic              acc_start;
  logic              acc_done;
  acc_result_t       acc_res;

  logic              decay_start;
  logic              dec_run_done;
  logic              dec_sleep_done;
  logic [AVG_W-1:0]  dec_run_in;
  logic [AVG_W-1:0]  dec_sleep_in;
  logic [AVG_W-1:0]  dec_run;
  logic [AVG_W-1:0]  dec_sleep;

  logic              score_start;
  logic              score_done;
  logic [SCORE_W-1:0] score;

  logic [AVG_W-1:0]  run_fin;
  logic [AVG_W-1:0]  sleep_fin;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_slot    = in_tdata[SLOT_W-1:0];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Free the output register first, then retire the transaction into it
  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Entries never written since reset read as zero
  assign run_base   = valid_rd_r ? run_rd : '0;
  assign sleep_base = valid_rd_r ? sleep_rd : '0;

  // Past twice the limit: drop run history and pin sleep at the limit
  assign dec_run_in   = acc_res.over_twice ? '0 : acc_res.run_sum[AVG_W-1:0];
  assign dec_sleep_in = acc_res.over_twice ? AVG_W'(limit_r)
                                           : acc_res.sleep_sum[AVG_W-1:0];

  // Within the limit the sums never exceed it, so they fit the average width
  assign run_fin   = acc_res.over_limit ? dec_run : acc_res.run_sum[AVG_W-1:0];
  assign sleep_fin = acc_res.over_limit ? dec_sleep : acc_res.sleep_sum[AVG_W-1:0];

  assign acc_start   = (state_r == ST_READ);
  assign decay_start = (state_r == ST_ACC) && acc_done;
  assign score_start = (state_r == ST_DECAY) && dec_run_done && dec_sleep_done;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_accept) begin
                  state_nxt = ST_READ;
                end
      ST_READ:  state_nxt = ST_ACC;
      ST_ACC:   if (acc_done) begin
                  state_nxt = ST_DECAY;
                end
      ST_DECAY: if (score_start) begin
                  state_nxt = ST_SCORE;
                end
      ST_SCORE: if (score_done) begin
                  state_nxt = ST_DONE;
                end
      ST_DONE:  if (out_load) begin
                  state_nxt = ST_IDLE;
                end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {{OUT_PAD_W{1'b0}}, sleep_fin, run_fin, score};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // History limit register and per-slot valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      valid_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (out_load) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  // Capture the transaction; table data arrives alongside the valid bit
  always_ff @(posedge clk) begin
    if (in_accept) begin
      slot_r     <= in_slot;
      ran_r      <= in_tdata[SLOT_W +: TIME_W];
      slept_r    <= in_tdata[SLOT_W + TIME_W +: TIME_W];
      valid_rd_r <= valid_r[in_slot];
    end
  end

  tis_ram #(
    .WIDTH (AVG_W),
    .DEPTH (THREAD_SLOTS)
  ) u_run_table (
    .clk     (clk),
    .wr_en   (out_load),
    .wr_addr (slot_r),
    .wr_data (run_fin),
    .rd_en   (in_accept),
    .rd_addr (in_slot),
    .rd_data (run_rd)
  );

  tis_ram #(
    .WIDTH (AVG_W),
    .DEPTH (THREAD_SLOTS)
  ) u_sleep_table (
    .clk     (clk),
    .wr_en   (out_load),
    .wr_addr (slot_r),
    .wr_data (sleep_fin),
    .rd_en   (in_accept),
    .rd_addr (in_slot),
    .rd_data (sleep_rd)
  );

  tis_serial_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (acc_start),
    .run_base   (run_base),
    .sleep_base (sleep_base),
    .ran_us     (ran_r),
    .slept_us   (slept_r),
    .limit      (limit_r),
    .done       (acc_done),
    .result     (acc_res)
  );

  tis_decay u_decay_run (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (decay_start),
    .value  (dec_run_in),
    .done   (dec_run_done),
    .result (dec_run)
  );

  tis_decay u_decay_sleep (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (decay_start),
    .value  (dec_sleep_in),
    .done   (dec_sleep_done),
    .result (dec_sleep)
  );

  tis_score_div u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (score_start),
    .run_avg   (run_fin),
    .sleep_avg (sleep_fin),
    .done      (score_done),
    .score     (score)
  );

endmodule

`default_nettype wire

// File: tb/sv/tis_score_checker.sv
// ----------------------------------------------------------------------------
// Thread interactivity score - scoreboard
// Watches the input, result and register channels of the score unit, keeps its
// own copy of the per-slot averages and the history limit, forecasts each
// result and compares it field by field with what the unit delivers.
// ----------------------------------------------------------------------------
`default_nettype none

module tis_score_checker
  import tis_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_W-1:0]     cfg_wr_data,
  output int unsigned            pending,
  output int unsigned            fail_count
);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [AVG_W-1:0]   run_avg;
    logic [AVG_W-1:0]   sleep_avg;
  } score_rec_t;

  logic [LIMIT_W-1:0] history_limit_q;
  logic [AVG_W-1:0]   run_avg_mem   [THREAD_SLOTS];
  logic [AVG_W-1:0]   sleep_avg_mem [THREAD_SLOTS];
  score_rec_t         expected_q [$];
  int unsigned        mismatch_total = 0;

  function automatic logic [SCORE_W-1:0] score_for(input logic [63:0] run_t,
                                                   input logic [63:0] sleep_t);
    logic [63:0] s;
    if (sleep_t > run_t)
      s = (64'(HALF_SCORE) * run_t) / sleep_t;
    else if (run_t == 0)
      s = 64'(HALF_SCORE);    // both averages zero: no division
    else
      s = (64'(HALF_SCORE) * sleep_t) / run_t + 64'(HALF_SCORE);
    if (s > 64'(MAX_SCORE))
      s = 64'(MAX_SCORE);
    return s[SCORE_W-1:0];
  endfunction

  // Fold elapsed times into a slot, decay past the limit, update the tables.
  function automatic score_rec_t fold_sample(input logic [SLOT_W-1:0] slot,
                                             input logic [TIME_W-1:0] ran,
                                             input logic [TIME_W-1:0] slept);
    logic [63:0] run_t;
    logic [63:0] sleep_t;
    logic [63:0] total;
    logic [63:0] lim;
    score_rec_t  rec;
    lim     = 64'(history_limit_q);
    run_t   = 64'(run_avg_mem[slot]) + 64'(ran);
    sleep_t = 64'(sleep_avg_mem[slot]) + 64'(slept);
    total   = run_t + sleep_t;
    if (total > lim) begin
      if (total > lim * 2) begin
        run_t   = '0;
        sleep_t = lim;
      end
      run_t   = run_t * 4 / 5;
      sleep_t = sleep_t * 4 / 5;
    end
    run_t   = run_t & ((64'd1 << AVG_W) - 1);
    sleep_t = sleep_t & ((64'd1 << AVG_W) - 1);
    run_avg_mem[slot]   = run_t[AVG_W-1:0];
    sleep_avg_mem[slot] = sleep_t[AVG_W-1:0];
    rec.score     = score_for(run_t, sleep_t);
    rec.run_avg   = run_t[AVG_W-1:0];
    rec.sleep_avg = sleep_t[AVG_W-1:0];
    return rec;
  endfunction

  always @(posedge clk) begin : monitor
    score_rec_t got;
    score_rec_t want;
    if (!rst_n) begin
      history_limit_q = LIMIT_RESET;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        run_avg_mem[i]   = '0;
        sleep_avg_mem[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (cfg_wr_en)
        history_limit_q = cfg_wr_data;
      // Results leave long after their transaction, so check before forecasting.
      if (out_tvalid && out_tready) begin
        got.score     = out_tdata[SCORE_W-1:0];
        got.run_avg   = out_tdata[SCORE_W +: AVG_W];
        got.sleep_avg = out_tdata[SCORE_W+AVG_W +: AVG_W];
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding: score %0d run %0d sleep %0d",
                 got.score, got.run_avg, got.sleep_avg);
          mismatch_total++;
        end else begin
          want = expected_q.pop_front();
          if (got.score !== want.score) begin
            $error("score: expected %0d, got %0d", want.score, got.score);
            mismatch_total++;
          end
          if (got.run_avg !== want.run_avg) begin
            $error("run_average: expected %0d, got %0d", want.run_avg, got.run_avg);
            mismatch_total++;
          end
          if (got.sleep_avg !== want.sleep_avg) begin
            $error("sleep_average: expected %0d, got %0d", want.sleep_avg, got.sleep_avg);
            mismatch_total++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(fold_sample(in_tdata[SLOT_W-1:0],
                                         in_tdata[SLOT_W +: TIME_W],
                                         in_tdata[SLOT_W+TIME_W +: TIME_W]));
    end
    pending    <= expected_q.size();
    fail_count <= mismatch_total;
  end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Thread interactivity score unit - testbench top
// Drives transactions into the unit through several history limits and
// handshake pressure patterns; the scoreboard alongside forecasts and checks
// every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import tis_pkg::*;

  // No acceptance on either channel for this long means the unit is stuck.
  localparam int WATCHDOG_CYCLES = 5000;
  // A little over the latency of the unit.
  localparam int SETTLE_CYCLES   = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [5:0] slot, [37:6] ran_us, [69:38] slept_us
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [6:0] score, [37:7] run_avg, [68:38] sleep_avg
  logic                  cfg_wr_en;
  logic [LIMIT_W-1:0]    cfg_wr_data;

  int unsigned           pending;
  int unsigned           fail_count;
  int unsigned           idle_pct   = 0;   // chance per cycle that the source holds off
  int unsigned           stall_pct  = 0;   // chance per cycle that the sink stalls
  int unsigned           quiet_cycles = 0;
  logic [LIMIT_W-1:0]    limit_now;        // limit in force, used to scale the stimulus

  thread_interactivity_score_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tis_score_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sink side: stall at random according to the current pressure pattern.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one transaction, holding off at random first, and wait for acceptance.
  // Leave tvalid high afterwards so back-to-back transactions need no toggling.
  task automatic send_sample(input logic [SLOT_W-1:0] slot,
                             input logic [TIME_W-1:0] ran,
                             input logic [TIME_W-1:0] slept);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, slept, ran, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and hold until every forecast result has come back, then let
  // the unit settle. The first edge lets the scoreboard count the last push.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the history limit only while the unit is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now    = value;
  endtask

  // Elapsed times mostly sized against the limit so that sums straddle it;
  // now and then zero or a full 32-bit value.
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned span;
    span = (int'(limit_now) >> $urandom_range(3)) + 2;
    case ($urandom_range(9))
      0: return $urandom;
      1: return '0;
      default: return $urandom_range(span, 0);
    endcase
  endfunction

  // Model scheduler traffic: wakeups carry only sleep time, stops only run
  // time, and the odd event carries both. Favour a few slots so that their
  // history builds up and decays.
  task automatic random_samples(input int count, input bit hold_mid);
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] ran;
    logic [TIME_W-1:0] slept;
    int unsigned       kind;
    for (int i = 0; i < count; i++) begin
      if (hold_mid && i == count / 2)
        drain();
      slot = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(3)) : SLOT_W'($urandom);
      kind = $urandom_range(9);
      ran   = (kind < 4) ? '0 : pick_time();
      slept = (kind >= 4 && kind < 8) ? '0 : pick_time();
      send_sample(slot, ran, slept);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    limit_now    = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed transactions under the reset limit, no idling.
    send_sample(6'd0,  32'd0, 32'd0);                 // both averages zero: half score
    send_sample(6'd63, 32'hFFFF_FFFF, 32'd0);         // far past twice the limit
    send_sample(6'd63, 32'd0, 32'hFFFF_FFFF);
    send_sample(6'd1,  32'd1000, 32'd0);              // run only
    send_sample(6'd1,  32'd0, 32'd3000);              // sleep above run
    send_sample(6'd2,  32'd3_000_000, 32'd0);
    send_sample(6'd2,  32'd0, 32'd2_500_000);         // past the limit: decay only
    send_sample(6'd3,  32'd4000, 32'd4000);           // equal averages: maximum score
    send_sample(6'd4,  32'd0, 32'd5_000_000);         // exactly at the limit
    send_sample(6'd4,  32'd0, 32'd0);
    send_sample(6'd4,  32'd1, 32'd0);                 // one past the limit
    send_sample(6'd5,  32'd6_000_000, 32'd4_000_000); // exactly twice the limit
    send_sample(6'd5,  32'd6_000_000, 32'd4_000_001); // past twice the limit
    send_sample(6'd7,  32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(6'd62, 32'hAAAA_AAAA, 32'h5555_5555);
    random_samples(280, 1'b0);

    // Smallest nonzero limit; source idles about half the time.
    idle_pct = 51;
    write_limit(30'd1);
    random_samples(200, 1'b0);

    // Large limit below the 30-bit maximum; sink stalls about half the time.
    idle_pct  = 0;
    stall_pct = 51;
    write_limit(30'd1_000_000_000);
    random_samples(300, 1'b0);

    // Full 30-bit limit; both sides idle now and then.
    idle_pct  = 21;
    stall_pct = 21;
    write_limit(30'h3FFF_FFFF);
    random_samples(200, 1'b0);

    // Zero limit: any nonzero sum clears the slot, a zero sum leaves it at zero.
    write_limit(30'd0);
    send_sample(6'd9,  32'd0, 32'd0);
    send_sample(6'd9,  32'd1, 32'd0);
    send_sample(6'd9,  32'd0, 32'd0);
    send_sample(6'd10, 32'd0, 32'd7);
    random_samples(120, 1'b0);

    // Small limit at full rate; hold the source halfway until all is back.
    idle_pct  = 0;
    stall_pct = 0;
    write_limit(30'd5000);
    random_samples(200, 1'b1);

    // Back to the reset value with an idling source.
    idle_pct = 51;
    write_limit(LIMIT_RESET);
    random_samples(280, 1'b0);

    drain();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
